// ===== rtl/core/ppc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the positional PID controller: register
// map, state encodings and the configuration register bundle.
// ----------------------------------------------------------------------------
package ppc_pkg;

  // Configuration port geometry.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_GAIN_P        = 3'd0;
  localparam logic [2:0] REG_GAIN_I        = 3'd1;
  localparam logic [2:0] REG_GAIN_D        = 3'd2;
  localparam logic [2:0] REG_TARGET        = 3'd3;
  localparam logic [2:0] REG_DRIVE_FLOOR   = 3'd4;
  localparam logic [2:0] REG_DRIVE_CEILING = 3'd5;
  localparam logic [2:0] REG_ACCUM_FLOOR   = 3'd6;
  localparam logic [2:0] REG_ACCUM_CEILING = 3'd7;

  // Limits of the signed 32-bit range.
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

  // All configuration registers as one bundle.
  typedef struct packed {
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic signed [31:0] target;
    logic signed [31:0] drive_floor;
    logic signed [31:0] drive_ceiling;
    logic signed [31:0] accum_floor;
    logic signed [31:0] accum_ceiling;
  } cfg_regs_t;

  // Main sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INC_MUL,
    S_ACC_ADD,
    S_ACC_CLAMP,
    S_DIV_START,
    S_DIV_WAIT,
    S_TERM_P,
    S_TERM_I,
    S_TERM_D,
    S_TERM_SUM,
    S_OUT_SAT,
    S_OUT_CLAMP
  } state_e;

  // Divider states.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX
  } div_state_e;

endpackage

// ===== rtl/core/ppc_in_if.sv =====
// ----------------------------------------------------------------------------
// ppc_in_if
// Request channel of the controller: one measurement and its time step.
// ----------------------------------------------------------------------------
interface ppc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measured;
  logic        [31:0] step_time;

  modport source (output valid, output measured, output step_time, input ready);
  modport sink   (input valid, input measured, input step_time, output ready);
endinterface

// ===== rtl/core/ppc_out_if.sv =====
// ----------------------------------------------------------------------------
// ppc_out_if
// Result channel of the controller: the clamped drive and the zero-step flag.
// ----------------------------------------------------------------------------
interface ppc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               zero_step;

  modport source (output valid, output drive, output zero_step, input ready);
  modport sink   (input valid, input drive, input zero_step, output ready);
endinterface

// ===== rtl/core/ppc_cfg.sv =====
// ----------------------------------------------------------------------------
// ppc_cfg
// APB-style register file holding gains, setpoint and the two clamp windows.
// ----------------------------------------------------------------------------
module ppc_cfg import ppc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         cfg_o
);

  cfg_regs_t   regs_q;
  logic [2:0]  idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = regs_q;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.gain_p        <= '0;
      regs_q.gain_i        <= '0;
      regs_q.gain_d        <= '0;
      regs_q.target        <= '0;
      regs_q.drive_floor   <= S32_MIN;
      regs_q.drive_ceiling <= S32_MAX;
      regs_q.accum_floor   <= S32_MIN;
      regs_q.accum_ceiling <= S32_MAX;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_GAIN_P:        regs_q.gain_p        <= pwdata;
        REG_GAIN_I:        regs_q.gain_i        <= pwdata;
        REG_GAIN_D:        regs_q.gain_d        <= pwdata;
        REG_TARGET:        regs_q.target        <= pwdata;
        REG_DRIVE_FLOOR:   regs_q.drive_floor   <= pwdata;
        REG_DRIVE_CEILING: regs_q.drive_ceiling <= pwdata;
        REG_ACCUM_FLOOR:   regs_q.accum_floor   <= pwdata;
        REG_ACCUM_CEILING: regs_q.accum_ceiling <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (idx)
      REG_GAIN_P:        prdata = regs_q.gain_p;
      REG_GAIN_I:        prdata = regs_q.gain_i;
      REG_GAIN_D:        prdata = regs_q.gain_d;
      REG_TARGET:        prdata = regs_q.target;
      REG_DRIVE_FLOOR:   prdata = regs_q.drive_floor;
      REG_DRIVE_CEILING: prdata = regs_q.drive_ceiling;
      REG_ACCUM_FLOOR:   prdata = regs_q.accum_floor;
      REG_ACCUM_CEILING: prdata = regs_q.accum_ceiling;
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/ppc_mul.sv =====
// ----------------------------------------------------------------------------
// ppc_mul
// Shared signed 33x33 multiplier with a registered product. The product is
// offered only shifted right by the fraction width, rounded toward minus
// infinity.
// ----------------------------------------------------------------------------
module ppc_mul import ppc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [63:0] shr_o
);

  logic signed [65:0] prod_q;

  // One multiplication per cycle, product registered.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // An arithmetic shift floors; the result always fits in 64 bits.
  assign shr_o = 64'(prod_q >>> FRAC_BITS);

endmodule

// ===== rtl/core/ppc_div.sv =====
// ----------------------------------------------------------------------------
// ppc_div
// Restoring divider for the derivative: (delta << FRAC_BITS) / divisor,
// truncated toward zero and saturated to signed 32 bits. One quotient bit
// is produced per cycle.
// ----------------------------------------------------------------------------
module ppc_div import ppc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] delta_i,
  input  logic        [31:0] divisor_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);

  localparam int unsigned NUM_W = 33 + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  div_state_e         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic               neg_q, neg_d;
  logic [NUM_W-1:0]   dvd_q, dvd_d;
  logic [32:0]        rem_q, rem_d;
  logic [31:0]        dsr_q, dsr_d;
  logic signed [31:0] quot_q, quot_d;

  logic [32:0]        mag;
  logic [32:0]        trial;
  logic               ge;
  logic               hi_nz;

  // Magnitude of the signed difference; 2^32 still fits.
  assign mag   = delta_i[32] ? (~delta_i + 33'd1) : delta_i;
  assign trial = {rem_q[31:0], dvd_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign hi_nz = |dvd_q[NUM_W-1:32];

  // Sequencer and shift-subtract step.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    neg_d   = neg_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    quot_d  = quot_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          neg_d   = delta_i[32];
          dvd_d   = {mag, {FRAC_BITS{1'b0}}};
          rem_d   = '0;
          dsr_d   = divisor_i;
          cnt_d   = CNT_W'(NUM_W);
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        rem_d = ge ? (trial - {1'b0, dsr_q}) : trial;
        dvd_d = {dvd_q[NUM_W-2:0], ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = DIV_FIX;
        end
      end
      DIV_FIX: begin
        // Apply the sign and saturate the quotient.
        if (neg_q) begin
          if (hi_nz || (dvd_q[31] && (|dvd_q[30:0]))) begin
            quot_d = S32_MIN;
          end else begin
            quot_d = -$signed(dvd_q[31:0]);
          end
        end else begin
          if (hi_nz || dvd_q[31]) begin
            quot_d = S32_MAX;
          end else begin
            quot_d = $signed(dvd_q[31:0]);
          end
        end
        done_d  = 1'b1;
        state_d = DIV_IDLE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/positional_pid_controller.sv =====
// ----------------------------------------------------------------------------
// positional_pid_controller
// Positional PID controller in signed fixed point with integral clamp and
// output window.
// ----------------------------------------------------------------------------
// One request is processed at a time. With a nonzero step_time a request
// also waits for the bit-serial divider that forms the derivative with one
// quotient bit per cycle (data in Q16.16 at the default FRAC_BITS); with a
// zero step_time the divider is skipped. All products go through one shared
// registered multiplier, used four times per request. A finished result
// waits in an output register, so the next request is accepted while it is
// still pending.
module positional_pid_controller import ppc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  ppc_in_if.sink            sample_i,
  ppc_out_if.source         result_o
);

  cfg_regs_t          cfg;

  state_e             state_q, state_d;
  logic signed [31:0] accum_q, accum_d;
  logic signed [31:0] last_err_q, last_err_d;
  logic               out_valid_q, out_valid_d;

  logic signed [31:0] err_q, err_d;
  logic        [31:0] step_q, step_d;
  logic               zero_q, zero_d;
  logic signed [63:0] work_q, work_d;
  logic signed [31:0] deriv_q, deriv_d;
  logic signed [31:0] sat_q, sat_d;
  logic signed [31:0] drive_q, drive_d;
  logic               zflag_q, zflag_d;

  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] mul_shr;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_quot;
  logic signed [32:0] delta;
  logic signed [32:0] diff;
  logic signed [31:0] err_sat;
  logic               accept;

  // Clamp x to [lo, hi]; the floor is applied first, so the ceiling wins.
  function automatic logic signed [31:0] clamp_win(input logic signed [63:0] x,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
    logic signed [63:0] lo_w;
    logic signed [63:0] hi_w;
    lo_w = 64'(lo);
    hi_w = 64'(hi);
    if (x < lo_w) begin
      clamp_win = (lo > hi) ? hi : lo;
    end else begin
      clamp_win = (x > hi_w) ? hi : x[31:0];
    end
  endfunction

  ppc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .shr_o (mul_shr)
  );

  ppc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .delta_i   (delta),
    .divisor_i (step_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Error with saturation to the signed 32-bit range.
  assign diff    = 33'(cfg.target) - 33'(sample_i.measured);
  assign err_sat = (diff[32] != diff[31]) ? (diff[32] ? S32_MIN : S32_MAX) : diff[31:0];
  assign delta   = 33'(err_q) - 33'(last_err_q);

  assign accept         = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == S_IDLE);

  assign result_o.valid     = out_valid_q;
  assign result_o.drive     = drive_q;
  assign result_o.zero_step = zflag_q;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_INC_MUL: begin
        mul_a = 33'(err_q);
        mul_b = $signed({1'b0, step_q});
      end
      S_TERM_P: begin
        mul_a = 33'(cfg.gain_p);
        mul_b = 33'(err_q);
      end
      S_TERM_I: begin
        mul_a = 33'(cfg.gain_i);
        mul_b = 33'(accum_q);
      end
      S_TERM_D: begin
        mul_a = 33'(cfg.gain_d);
        mul_b = 33'(deriv_q);
      end
      default: ;
    endcase
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d     = state_q;
    accum_d     = accum_q;
    last_err_d  = last_err_q;
    out_valid_d = out_valid_q;
    err_d       = err_q;
    step_d      = step_q;
    zero_d      = zero_q;
    work_d      = work_q;
    deriv_d     = deriv_q;
    sat_d       = sat_q;
    drive_d     = drive_q;
    zflag_d     = zflag_q;
    div_start   = 1'b0;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          err_d   = err_sat;
          step_d  = sample_i.step_time;
          zero_d  = (sample_i.step_time == '0);
          state_d = S_INC_MUL;
        end
      end
      S_INC_MUL: state_d = S_ACC_ADD;
      S_ACC_ADD: begin
        work_d  = 64'(accum_q) + mul_shr;
        state_d = S_ACC_CLAMP;
      end
      S_ACC_CLAMP: begin
        accum_d = clamp_win(work_q, cfg.accum_floor, cfg.accum_ceiling);
        state_d = S_DIV_START;
      end
      S_DIV_START: begin
        // A zero step drops the derivative and skips the divider.
        if (zero_q) begin
          deriv_d = '0;
          state_d = S_TERM_P;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          deriv_d = div_quot;
          state_d = S_TERM_P;
        end
      end
      S_TERM_P: state_d = S_TERM_I;
      S_TERM_I: begin
        work_d  = mul_shr;
        state_d = S_TERM_D;
      end
      S_TERM_D: begin
        work_d  = work_q + mul_shr;
        state_d = S_TERM_SUM;
      end
      S_TERM_SUM: begin
        work_d  = work_q + mul_shr;
        state_d = S_OUT_SAT;
      end
      S_OUT_SAT: begin
        if (!work_q[63] && (|work_q[62:31])) begin
          sat_d = S32_MAX;
        end else if (work_q[63] && !(&work_q[62:31])) begin
          sat_d = S32_MIN;
        end else begin
          sat_d = work_q[31:0];
        end
        state_d = S_OUT_CLAMP;
      end
      S_OUT_CLAMP: begin
        // Load the output register once the previous result is gone.
        if (!out_valid_q || result_o.ready) begin
          drive_d     = clamp_win(64'(sat_q), cfg.drive_floor, cfg.drive_ceiling);
          zflag_d     = zero_q;
          out_valid_d = 1'b1;
          last_err_d  = err_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and controller memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      accum_q     <= '0;
      last_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      accum_q     <= accum_d;
      last_err_q  <= last_err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    step_q  <= step_d;
    zero_q  <= zero_d;
    work_q  <= work_d;
    deriv_q <= deriv_d;
    sat_q   <= sat_d;
    drive_q <= drive_d;
    zflag_q <= zflag_d;
  end

`ifndef SYNTH
  // A request is followed by a busy period.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !sample_i.ready)
    else $error("controller ready right after accepting a request");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV_WAIT))
    else $error("divider finished outside its wait state");

  // A pending result never exceeds the output ceiling.
  a_drive_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (drive_q <= cfg.drive_ceiling))
    else $error("drive above the configured ceiling");

  // A zero step never starts the divider.
  a_zero_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !zero_q)
    else $error("divider started for a zero step");
`endif

endmodule

// ===== verif/positional_pid_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_pid_controller_tb
// Self-checking bench for the positional PID controller. A driver and a
// monitor run as clocked processes around the request and result channels.
// An in-bench predictor keeps its own integral, previous error and register
// copy, and checks every result in order. Registers are set over the APB
// port between phases: directed extremes first, then randomized settings
// with random request streams, idle bursts and one long result stall.
// ----------------------------------------------------------------------------
module positional_pid_controller_tb;
  import ppc_pkg::*;

  localparam int unsigned FRAC        = 16;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 105;
  localparam int unsigned END_DRAIN   = 100;

  typedef struct packed {
    logic signed [31:0] measured;
    logic        [31:0] step_time;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               zero_step;
  } drive_res_t;

  logic              clk;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ppc_in_if  sample_if ();
  ppc_out_if result_if ();

  positional_pid_controller #(
    .FRAC_BITS (FRAC)
  ) u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  // Pending requests, expected drives and the predictor's own state.
  sample_t            sample_pend_q[$];
  drive_res_t         drive_expect_q[$];
  cfg_regs_t          cfg_shadow;
  logic signed [31:0] integ_q;
  logic signed [31:0] prev_err_q;

  // Flow control shared between the stimulus and the channel processes.
  logic        sample_taken;
  logic        calm;
  logic        gaps_on;
  logic        long_hold_arm;
  logic        long_hold_seen;
  int unsigned send_gap;
  int unsigned hold_cnt;
  int unsigned quiet_cycles;

  // Run statistics.
  int unsigned n_mismatch;
  int unsigned n_results;
  int unsigned n_zero;
  int unsigned n_cfg_writes;
  int unsigned n_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate to the signed 32-bit range.
  function automatic longint clip_s32(input longint x);
    if (x > longint'(S32_MAX)) return longint'(S32_MAX);
    if (x < longint'(S32_MIN)) return longint'(S32_MIN);
    return x;
  endfunction

  // Floor first, ceiling second, so an inverted window yields the ceiling.
  function automatic longint bound_to(input longint x, input longint lo, input longint hi);
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    return x;
  endfunction

  // Advance the controller state by one request and return the drive.
  function automatic drive_res_t predict_drive(input sample_t s);
    longint     err;
    longint     acc;
    longint     deriv;
    longint     sum;
    longint     dt;
    drive_res_t r;
    dt  = longint'({32'd0, s.step_time});
    err = clip_s32(longint'(cfg_shadow.target) - longint'(s.measured));
    acc = longint'(integ_q) + ((err * dt) >>> FRAC);
    acc = clip_s32(bound_to(acc, cfg_shadow.accum_floor, cfg_shadow.accum_ceiling));
    deriv = 0;
    if (dt != 0) begin
      deriv = clip_s32(((err - longint'(prev_err_q)) * (longint'(1) << FRAC)) / dt);
    end
    sum = ((longint'(cfg_shadow.gain_p) * err) >>> FRAC)
        + ((longint'(cfg_shadow.gain_i) * acc) >>> FRAC)
        + ((longint'(cfg_shadow.gain_d) * deriv) >>> FRAC);
    sum = bound_to(clip_s32(sum), cfg_shadow.drive_floor, cfg_shadow.drive_ceiling);
    integ_q     = acc[31:0];
    prev_err_q  = err[31:0];
    r.drive     = sum[31:0];
    r.zero_step = (dt == 0);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    n_mismatch++;
  endtask

  task automatic queue_sample(input logic [31:0] meas, input logic [31:0] dt);
    sample_t s;
    s.measured  = meas;
    s.step_time = dt;
    sample_pend_q.push_back(s);
  endtask

  // Write one register, mirror it in the predictor, then read it back.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_GAIN_P:        cfg_shadow.gain_p        = val;
      REG_GAIN_I:        cfg_shadow.gain_i        = val;
      REG_GAIN_D:        cfg_shadow.gain_d        = val;
      REG_TARGET:        cfg_shadow.target        = val;
      REG_DRIVE_FLOOR:   cfg_shadow.drive_floor   = val;
      REG_DRIVE_CEILING: cfg_shadow.drive_ceiling = val;
      REG_ACCUM_FLOOR:   cfg_shadow.accum_floor   = val;
      REG_ACCUM_CEILING: cfg_shadow.accum_ceiling = val;
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (rd !== val) flag_mismatch($sformatf("readback of register %0d", idx), rd, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold the sender until every request has been answered.
  task automatic wait_settled();
    while (sample_pend_q.size() != 0 || sample_if.valid || drive_expect_q.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_target();
    case ($urandom_range(0, 9))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
    endcase
  endfunction

  function automatic void pick_window(output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] a;
    logic [31:0] b;
    int unsigned span;
    a = $urandom();
    b = $urandom();
    case ($urandom_range(0, 4))
      1: begin
        lo = ($signed(a) <= $signed(b)) ? a : b;
        hi = ($signed(a) <= $signed(b)) ? b : a;
      end
      2: begin
        span = $urandom_range(1, 32'h0008_0000);
        lo   = -span;
        hi   = span;
      end
      3: begin
        // Inverted window: floor above ceiling.
        span = $urandom_range(1, 32'h0001_0000);
        lo   = span;
        hi   = -span;
      end
      default: begin
        lo = S32_MIN;
        hi = S32_MAX;
      end
    endcase
  endfunction

  // Mostly readings near the setpoint, with some full-range noise.
  function automatic logic [31:0] pick_measured(input logic [31:0] tgt);
    case ($urandom_range(0, 19))
      0:       return S32_MIN;
      1:       return S32_MAX;
      2, 3, 4: return $urandom();
      5, 6:    return tgt;
      default: return tgt + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 19))
      0, 1:    return 32'd0;
      2:       return 32'hFFFF_FFFF;
      3, 4, 5: return $urandom();
      6, 7:    return $urandom_range(1, 16);
      default: return $urandom_range(1, 32'h0000_4000);
    endcase
  endfunction

  // Request driver: holds an offered request until it is taken.
  always @(negedge clk) begin
    sample_t nxt;
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
    end else if (!sample_if.valid || sample_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        sample_if.valid <= 1'b0;
      end else if (sample_pend_q.size() == 0) begin
        sample_if.valid <= 1'b0;
      end else if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 9);
        sample_if.valid <= 1'b0;
      end else begin
        nxt = sample_pend_q.pop_front();
        sample_if.valid     <= 1'b1;
        sample_if.measured  <= nxt.measured;
        sample_if.step_time <= nxt.step_time;
      end
    end
  end

  // Result receiver: short random stalls and one long hold-off.
  always @(negedge clk) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (long_hold_arm && !long_hold_seen) begin
        long_hold_seen = 1'b1;
        hold_cnt       = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        result_if.ready <= 1'b0;
      end else if (!calm && gaps_on && $urandom_range(0, 6) == 0) begin
        hold_cnt = $urandom_range(0, 9);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: check results in order, predict each accepted request.
  always @(posedge clk) begin
    drive_res_t want;
    sample_t    s;
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        n_results++;
        if (result_if.zero_step) n_zero++;
        if (drive_expect_q.size() == 0) begin
          flag_mismatch("result with no request pending", result_if.drive, 0);
        end else begin
          want = drive_expect_q.pop_front();
          if (result_if.drive !== want.drive)
            flag_mismatch("drive", result_if.drive, want.drive);
          if (result_if.zero_step !== want.zero_step)
            flag_mismatch("zero_step", result_if.zero_step, want.zero_step);
        end
      end
      if (sample_if.valid && sample_if.ready) begin
        s.measured  = sample_if.measured;
        s.step_time = sample_if.step_time;
        drive_expect_q.push_back(predict_drive(s));
      end
    end
    sample_taken <= rst_ni && sample_if.valid && sample_if.ready;
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_ni || (sample_if.valid && sample_if.ready) ||
        (result_if.valid && result_if.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, drive_expect_q.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] tgt;

    // Known values on every input before the first edge.
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    sample_if.valid     = 1'b0;
    sample_if.measured  = '0;
    sample_if.step_time = '0;
    result_if.ready     = 1'b0;
    sample_taken        = 1'b0;
    calm                = 1'b0;
    gaps_on             = 1'b1;
    long_hold_arm       = 1'b0;
    long_hold_seen      = 1'b0;
    send_gap            = 0;
    hold_cnt            = 0;
    quiet_cycles        = 0;
    n_mismatch          = 0;
    n_results           = 0;
    n_zero              = 0;
    n_cfg_writes        = 0;
    n_settings          = 1;

    // Predictor state after reset.
    cfg_shadow               = '0;
    cfg_shadow.drive_floor   = S32_MIN;
    cfg_shadow.drive_ceiling = S32_MAX;
    cfg_shadow.accum_floor   = S32_MIN;
    cfg_shadow.accum_ceiling = S32_MAX;
    integ_q                  = '0;
    prev_err_q               = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Register values straight out of reset.
    queue_sample(32'h1234_5678, 32'h0001_0000);
    queue_sample(S32_MIN, 32'd0);
    wait_settled();

    // Unit-scale gains with field extremes and a zero step.
    cfg_write(REG_GAIN_P, 32'h0001_0000);
    cfg_write(REG_GAIN_I, 32'h0000_8000);
    cfg_write(REG_GAIN_D, 32'h0000_4000);
    cfg_write(REG_TARGET, 32'h0002_0000);
    n_settings++;
    queue_sample(32'h0001_0000, 32'h0000_1000);
    queue_sample(32'h0002_0000, 32'd0);
    queue_sample(S32_MAX, 32'd1);
    queue_sample(S32_MIN, 32'hFFFF_FFFF);
    queue_sample(32'd0, 32'hFFFF_FFFF);
    queue_sample(32'hFFFF_FFFF, 32'd1);
    queue_sample(32'h0002_0000, 32'h0001_0000);
    queue_sample(S32_MIN, 32'd0);
    wait_settled();

    // Full-scale gains, positive error overflow, narrow windows.
    cfg_write(REG_GAIN_P, S32_MAX);
    cfg_write(REG_GAIN_I, S32_MIN);
    cfg_write(REG_GAIN_D, S32_MAX);
    cfg_write(REG_TARGET, S32_MAX);
    cfg_write(REG_DRIVE_FLOOR, 32'hFFFF_0000);
    cfg_write(REG_DRIVE_CEILING, 32'h0001_0000);
    cfg_write(REG_ACCUM_FLOOR, 32'hFFF0_0000);
    cfg_write(REG_ACCUM_CEILING, 32'h0010_0000);
    n_settings++;
    queue_sample(S32_MIN, 32'h0001_0000);
    queue_sample(S32_MAX, 32'd0);
    queue_sample(S32_MIN, 32'hFFFF_FFFF);
    queue_sample(32'd0, 32'd1);
    wait_settled();

    // Inverted windows and negative error overflow.
    cfg_write(REG_GAIN_P, 32'h0002_0000);
    cfg_write(REG_GAIN_I, S32_MAX);
    cfg_write(REG_GAIN_D, S32_MIN);
    cfg_write(REG_TARGET, S32_MIN);
    cfg_write(REG_DRIVE_FLOOR, 32'h0000_1000);
    cfg_write(REG_DRIVE_CEILING, 32'hFFFF_F000);
    cfg_write(REG_ACCUM_FLOOR, 32'd5);
    cfg_write(REG_ACCUM_CEILING, 32'hFFFF_FFFB);
    n_settings++;
    queue_sample(S32_MAX, 32'h0001_0000);
    queue_sample(32'd0, 32'd0);
    queue_sample(S32_MIN, 32'd1);
    queue_sample(32'h4000_0000, 32'hFFFF_FFFF);
    wait_settled();

    // Randomized settings, each followed by a stream of requests.
    for (int p = 0; p < RAND_PHASES; p++) begin
      cfg_write(REG_GAIN_P, pick_gain());
      cfg_write(REG_GAIN_I, pick_gain());
      cfg_write(REG_GAIN_D, pick_gain());
      tgt = pick_target();
      cfg_write(REG_TARGET, tgt);
      pick_window(lo, hi);
      cfg_write(REG_DRIVE_FLOOR, lo);
      cfg_write(REG_DRIVE_CEILING, hi);
      pick_window(lo, hi);
      cfg_write(REG_ACCUM_FLOOR, lo);
      cfg_write(REG_ACCUM_CEILING, hi);
      n_settings++;
      gaps_on = (p % 3) != 2;
      calm    = (p == RAND_PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) queue_sample(pick_measured(tgt), pick_step());
      // One long result stall while the sender keeps offering.
      if (p == 1) long_hold_arm = 1'b1;
      wait_settled();
    end

    repeat (END_DRAIN) @(posedge clk);
    $display("Covered %0d results, %0d with a zero time step, over %0d register settings",
             n_results, n_zero, n_settings);
    $display("using %0d register writes; windows ran full, narrow and inverted, with stalls",
             n_cfg_writes);
    if (n_mismatch == 0 && drive_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
